// ===== hw/rtl/shfc_pkg.sv =====
// shared types and constants for the stereo hrtf fir convolver
// no dependencies
`default_nettype none
package shfc_pkg;

  localparam int DEF_TAPS  = 256;
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int TAP_IDX_W = 8;
  localparam int OP_W      = 2;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;

  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_L = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD_R = 2'd2;

  typedef struct packed {
    logic clr;
    logic sample;
    logic load_l;
    logic load_r;
    logic rd_en;
    logic scale;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/shfc_if.sv =====
// channel interfaces: input word, result word, gain write
// depends on shfc_pkg
`default_nettype none
interface shfc_in_if;
  logic                               valid;
  logic                               ready;
  logic [shfc_pkg::OP_W-1:0]          op;
  logic [shfc_pkg::TAP_IDX_W-1:0]     tap_index;
  logic signed [shfc_pkg::SAMPLE_W-1:0] value;
  modport source (output valid, output op, output tap_index, output value, input ready);
  modport sink (input valid, input op, input tap_index, input value, output ready);
endinterface

interface shfc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [shfc_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [shfc_pkg::SAMPLE_W-1:0] right_sample;
  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface shfc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [shfc_pkg::GAIN_W-1:0]   output_gain;
  modport source (output valid, output output_gain, input ready);
  modport sink (input valid, input output_gain, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/shfc_ctrl.sv =====
// controller: clearing pass, word decode, mac sequencing, scale and output
// depends on shfc_pkg
`default_nettype none
module shfc_ctrl #(
  parameter int TAPS = shfc_pkg::DEF_TAPS,
  parameter int IDXW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [shfc_pkg::OP_W-1:0] in_op,
  output logic                           in_ready,
  input  wire shfc_pkg::sts_t            sts,
  output shfc_pkg::cmd_t                 cmd,
  output logic [IDXW-1:0]                idx
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [IDXW-1:0] LAST = IDXW'(TAPS - 1);

  logic [2:0]      state_r, state_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (idx_r == LAST) begin
          state_nxt = S_IDLE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            shfc_pkg::OP_SAMPLE: begin
              cmd.sample = 1'b1;
              state_nxt  = S_MAC;
              idx_nxt    = '0;
            end
            shfc_pkg::OP_LOAD_L: cmd.load_l = 1'b1;
            shfc_pkg::OP_LOAD_R: cmd.load_r = 1'b1;
            default: ;
          endcase
        end
      end
      S_MAC: begin
        cmd.rd_en = 1'b1;
        if (idx_r == LAST) begin
          state_nxt = S_DRAIN;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  assign idx = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // a sample starts the pass at tap zero
  a_sample_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == shfc_pkg::OP_SAMPLE) |=> (state_r == S_MAC && idx_r == '0))
    else $error("sample did not start mac pass");

  // the pass ends after the last tap
  a_mac_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC && idx_r == LAST) |=> state_r == S_DRAIN)
    else $error("mac pass did not end at last tap");

  // the scale step only follows a drained pipe
  a_scale_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCALE) |-> ($past(state_r) == S_DRAIN && !$past(sts.pipe_busy)))
    else $error("scale before pipe drained");

endmodule
`default_nettype wire

// ===== hw/rtl/shfc_dp.sv =====
// datapath: delay line and tap memories, mac pipe, gain scale, output register
// depends on shfc_pkg and shfc_if
`default_nettype none
module shfc_dp #(
  parameter int TAPS = shfc_pkg::DEF_TAPS,
  parameter int IDXW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire shfc_pkg::cmd_t                    cmd,
  input  wire logic [IDXW-1:0]                   idx,
  output shfc_pkg::sts_t                         sts,
  input  wire logic [shfc_pkg::TAP_IDX_W-1:0]    in_tap_index,
  input  wire logic signed [shfc_pkg::SAMPLE_W-1:0] in_value,
  shfc_cfg_if.sink                               cfg_ch,
  shfc_out_if.source                             out_ch
);

  localparam int SW   = shfc_pkg::SAMPLE_W;
  localparam int PW   = 2 * SW;
  localparam int ACCW = PW + 1 + IDXW;
  localparam int SCW  = ACCW + shfc_pkg::GAIN_W + 1;
  localparam logic [IDXW-1:0] LAST = IDXW'(TAPS - 1);

  logic signed [SW-1:0] hist_mem [TAPS];
  logic signed [SW-1:0] ltap_mem [TAPS];
  logic signed [SW-1:0] rtap_mem [TAPS];

  logic [shfc_pkg::GAIN_W-1:0] gain_r;
  logic [shfc_pkg::GAIN_W-1:0] gain_eff;
  logic [IDXW-1:0]             head_r, head_nxt, rd_ptr_r;
  logic                        tap_ok;
  logic [IDXW-1:0]             tap_addr;

  logic signed [SW-1:0]   hist_q_r, ltap_q_r, rtap_q_r;
  logic                   rd_vld_r, prod_vld_r;
  logic signed [PW-1:0]   prod_l_r, prod_r_r;
  logic signed [ACCW-1:0] acc_l_r, acc_r_r;
  logic signed [SCW-1:0]  sc_l_r, sc_r_r;
  logic signed [SCW-1:0]  rnd_l, rnd_r;
  logic signed [SW-1:0]   sat_l, sat_r;
  logic                   out_valid_r;
  logic signed [SW-1:0]   out_l_r, out_r_r;

  function automatic logic signed [SW-1:0] round_sat(input logic signed [SCW-1:0] v);
    logic [SCW-PW-14:0] hi;
    hi = v[SCW-1:PW+13];
    if ((&hi) || !(|hi)) begin
      round_sat = v[PW+13:PW-2];
    end else if (v[SCW-1]) begin
      round_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      round_sat = {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  // gain register, capped at unity
  assign cfg_ch.ready = 1'b1;
  assign gain_eff = (gain_r > shfc_pkg::GAIN_UNITY) ? shfc_pkg::GAIN_UNITY : gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= shfc_pkg::GAIN_UNITY;
    end else if (cfg_ch.valid) begin
      gain_r <= cfg_ch.output_gain;
    end
  end

  // circular delay line, head holds the newest sample
  assign head_nxt = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign tap_ok   = 32'(in_tap_index) < TAPS;
  assign tap_addr = IDXW'(in_tap_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      rd_ptr_r <= '0;
    end else if (cmd.sample) begin
      head_r   <= head_nxt;
      rd_ptr_r <= head_nxt;
    end else if (cmd.rd_en) begin
      rd_ptr_r <= (rd_ptr_r == '0) ? LAST : rd_ptr_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      hist_mem[idx] <= '0;
    end else if (cmd.sample) begin
      hist_mem[head_nxt] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      ltap_mem[idx] <= '0;
    end else if (cmd.load_l && tap_ok) begin
      ltap_mem[tap_addr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      rtap_mem[idx] <= '0;
    end else if (cmd.load_r && tap_ok) begin
      rtap_mem[tap_addr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      hist_q_r <= hist_mem[rd_ptr_r];
      ltap_q_r <= ltap_mem[idx];
      rtap_q_r <= rtap_mem[idx];
    end
  end

  // multiply and accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.rd_en;
      prod_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_l_r <= hist_q_r * ltap_q_r;
    prod_r_r <= hist_q_r * rtap_q_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (prod_vld_r) begin
      acc_l_r <= acc_l_r + ACCW'(prod_l_r);
      acc_r_r <= acc_r_r + ACCW'(prod_r_r);
    end
  end

  assign sts.pipe_busy = rd_vld_r | prod_vld_r;

  // gain scale, then round and saturate into the output register
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      sc_l_r <= SCW'(acc_l_r * $signed({1'b0, gain_eff}));
      sc_r_r <= SCW'(acc_r_r * $signed({1'b0, gain_eff}));
    end
  end

  assign rnd_l = sc_l_r + (SCW'(1) <<< (PW - 3));
  assign rnd_r = sc_r_r + (SCW'(1) <<< (PW - 3));
  assign sat_l = round_sat(rnd_l);
  assign sat_r = round_sat(rnd_r);

  assign sts.out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_l_r <= sat_l;
      out_r_r <= sat_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.left_sample  = out_l_r;
  assign out_ch.right_sample = out_r_r;

  // a waiting word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_load && out_valid_r && !out_ch.ready))
    else $error("output word overwritten");

  // accumulation only follows a read, by way of the read and product valid registers
  a_acc_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    prod_vld_r |-> $past(cmd.rd_en, 2))
    else $error("accumulate without read");

endmodule
`default_nettype wire

// ===== hw/rtl/stereo_hrtf_fir_convolver.sv =====
// stereo hrtf fir convolver: a new input word is taken only in idle, after the
// output load of the previous sample; one shared mac pass reads TAPS entries
// of the delay line and tap memories, one per cycle, then the pipe drains, and a scale
// step and the output load follow. a waiting word holds off the next input; a tap load
// keeps the block idle. after reset a clearing pass zeroes all memories before the
// first input word is taken; gain writes are taken at any time and reset to unity
`default_nettype none
module stereo_hrtf_fir_convolver #(
  parameter int TAPS = shfc_pkg::DEF_TAPS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  shfc_in_if.sink     in_ch,
  shfc_out_if.source  out_ch,
  shfc_cfg_if.sink    cfg_ch
);

  localparam int IDXW = (TAPS > 1) ? $clog2(TAPS) : 1;

  shfc_pkg::cmd_t  cmd;
  shfc_pkg::sts_t  sts;
  logic [IDXW-1:0] idx;

  shfc_ctrl #(
    .TAPS (TAPS),
    .IDXW (IDXW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .idx      (idx)
  );

  shfc_dp #(
    .TAPS (TAPS),
    .IDXW (IDXW)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .idx          (idx),
    .sts          (sts),
    .in_tap_index (in_ch.tap_index),
    .in_value     (in_ch.value),
    .cfg_ch       (cfg_ch),
    .out_ch       (out_ch)
  );

endmodule
`default_nettype wire

// ===== tb/tb_stereo_hrtf_fir_convolver.sv =====
// self-checking testbench for the stereo hrtf fir convolver: random and directed
// tap loads and samples against a scoreboard that predicts each stereo word
// depends on shfc_pkg, the shfc_*_if interfaces and stereo_hrtf_fir_convolver
module tb_stereo_hrtf_fir_convolver;

  localparam int TAPS_TB = shfc_pkg::DEF_TAPS;
  localparam logic [shfc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int TAIL_CYCLES = TAPS_TB + 16;
  localparam int MAX_REPORTS = 10;
  localparam int PHASES = 9;
  localparam int PHASE_WORDS = 135;
  localparam int BURST_TAPS = 32;

  typedef logic signed [shfc_pkg::SAMPLE_W-1:0] pcm_t;
  typedef struct packed {
    pcm_t left;
    pcm_t right;
  } stereo_pair_t;

  class binaural_scoreboard;
    pcm_t history [TAPS_TB];
    pcm_t left_taps [TAPS_TB];
    pcm_t right_taps [TAPS_TB];
    logic [shfc_pkg::GAIN_W-1:0] gain;
    stereo_pair_t pending_pairs [$];
    int n_samples;
    int n_loads;
    int n_ignored;
    int n_results;
    int n_mismatches;

    function new();
      foreach (history[k]) begin
        history[k] = '0;
        left_taps[k] = '0;
        right_taps[k] = '0;
      end
      gain = shfc_pkg::GAIN_UNITY;
    endfunction

    function pcm_t scale_to_pcm(longint acc);
      longint g;
      longint q;
      g = gain;
      if (gain > shfc_pkg::GAIN_UNITY) g = shfc_pkg::GAIN_UNITY;
      q = (acc * g + (longint'(1) <<< 29)) >>> 30;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[shfc_pkg::SAMPLE_W-1:0];
    endfunction

    function void note_word(logic [shfc_pkg::OP_W-1:0] op,
                            logic [shfc_pkg::TAP_IDX_W-1:0] idx, pcm_t value);
      longint acc_l;
      longint acc_r;
      stereo_pair_t pair;
      int k;
      if (op == shfc_pkg::OP_LOAD_L || op == shfc_pkg::OP_LOAD_R) begin
        if (idx < TAPS_TB) begin
          if (op == shfc_pkg::OP_LOAD_L) left_taps[idx] = value;
          else right_taps[idx] = value;
          n_loads++;
        end else begin
          n_ignored++;
        end
      end else if (op == shfc_pkg::OP_SAMPLE) begin
        for (k = TAPS_TB - 1; k > 0; k--) history[k] = history[k-1];
        history[0] = value;
        acc_l = 0;
        acc_r = 0;
        for (k = 0; k < TAPS_TB; k++) begin
          acc_l += longint'(history[k]) * longint'(left_taps[k]);
          acc_r += longint'(history[k]) * longint'(right_taps[k]);
        end
        pair.left = scale_to_pcm(acc_l);
        pair.right = scale_to_pcm(acc_r);
        pending_pairs.push_back(pair);
        n_samples++;
      end else begin
        n_ignored++;
      end
    endfunction

    function void flag(string msg);
      n_mismatches++;
      if (n_mismatches <= MAX_REPORTS) $display("%0t %s", $time, msg);
    endfunction

    function void check_pair(pcm_t l, pcm_t r);
      stereo_pair_t want;
      n_results++;
      if (pending_pairs.size() == 0) begin
        flag($sformatf("stereo word with none pending: left %0d right %0d", l, r));
      end else begin
        want = pending_pairs.pop_front();
        if (l !== want.left)
          flag($sformatf("left sample: expected %0d, got %0d", want.left, l));
        if (r !== want.right)
          flag($sformatf("right sample: expected %0d, got %0d", want.right, r));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int in_idle_pct;
  int out_idle_pct;
  int n_gain_writes;
  binaural_scoreboard sb;

  shfc_in_if  in_ch();
  shfc_out_if out_ch();
  shfc_cfg_if cfg_ch();

  stereo_hrtf_fir_convolver #(.TAPS(TAPS_TB)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_pair(out_ch.left_sample, out_ch.right_sample);
  end

  function automatic pcm_t pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return pcm_t'($urandom);
    if (roll < 80) return pcm_t'(int'($urandom_range(2047)) - 1024);
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      4: return 16'sh0001;
      default: return 16'sh4000;
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_word(logic [shfc_pkg::OP_W-1:0] op,
                           logic [shfc_pkg::TAP_IDX_W-1:0] idx, pcm_t value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.tap_index <= idx;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(op, idx, value);
    @(negedge clk);
  endtask

  task automatic write_gain(logic [shfc_pkg::GAIN_W-1:0] g);
    cfg_ch.valid <= 1'b1;
    cfg_ch.output_gain <= g;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.gain = g;
    n_gain_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending_pairs.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  initial begin
    int phase;
    int k;
    int n;
    int goal;
    int roll;
    int base;
    logic [shfc_pkg::OP_W-1:0] ear;
    logic [shfc_pkg::GAIN_W-1:0] g;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = shfc_pkg::OP_SAMPLE;
    in_ch.tap_index = '0;
    in_ch.value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.output_gain = shfc_pkg::GAIN_UNITY;
    out_ch.ready = 1'b0;
    in_idle_pct = 15;
    out_idle_pct = 62;
    n_gain_writes = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words at the reset gain
    send_word(shfc_pkg::OP_SAMPLE, 8'd0, 16'sh7fff);
    send_word(shfc_pkg::OP_LOAD_L, 8'd0, 16'sh7fff);
    send_word(shfc_pkg::OP_LOAD_R, 8'd0, 16'sh8000);
    send_word(shfc_pkg::OP_LOAD_L, shfc_pkg::TAP_IDX_W'(TAPS_TB - 1), 16'sh8000);
    send_word(shfc_pkg::OP_LOAD_R, shfc_pkg::TAP_IDX_W'(TAPS_TB - 1), 16'sh7fff);
    send_word(shfc_pkg::OP_LOAD_L, 8'hff, 16'sh5555);
    send_word(shfc_pkg::OP_LOAD_R, shfc_pkg::TAP_IDX_W'(TAPS_TB), 16'shffff);
    send_word(OP_UNUSED, 8'haa, 16'sh7fff);
    send_word(shfc_pkg::OP_SAMPLE, 8'hff, 16'sh8000);
    send_word(shfc_pkg::OP_SAMPLE, 8'h55, 16'sh7fff);
    send_word(shfc_pkg::OP_SAMPLE, 8'd0, 16'shffff);
    send_word(shfc_pkg::OP_SAMPLE, 8'd0, 16'sh0001);
    send_word(shfc_pkg::OP_LOAD_L, 8'd1, 16'sh7fff);
    send_word(shfc_pkg::OP_LOAD_R, 8'd1, 16'sh7fff);
    repeat (3) send_word(shfc_pkg::OP_SAMPLE, 8'd0, 16'sh7fff);
    repeat (3) send_word(shfc_pkg::OP_SAMPLE, 8'd0, 16'sh8000);
    send_word(shfc_pkg::OP_SAMPLE, 8'd0, 16'sh0000);
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase / 3)
        0: begin
          in_idle_pct = 15;
          out_idle_pct = 62;
        end
        1: begin
          in_idle_pct = 62;
          out_idle_pct = 15;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
      endcase
      case (phase)
        0: g = 16'd32767;
        1: g = 16'd0;
        2: g = 16'hffff;
        3: g = 16'd16384;
        4: g = 16'd1;
        5: g = 16'd32769;
        6: g = shfc_pkg::GAIN_W'($urandom_range(shfc_pkg::GAIN_UNITY));
        7: g = shfc_pkg::GAIN_W'($urandom);
        default: g = shfc_pkg::GAIN_UNITY;
      endcase
      write_gain(g);
      goal = sb.n_samples + sb.n_loads + PHASE_WORDS;
      while (sb.n_samples + sb.n_loads < goal) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          // sparse block of taps for one ear
          ear = $urandom_range(1) ? shfc_pkg::OP_LOAD_L : shfc_pkg::OP_LOAD_R;
          base = BURST_TAPS * int'($urandom_range(TAPS_TB / BURST_TAPS - 1));
          for (k = base; k < base + BURST_TAPS; k++)
            send_word(ear, k[shfc_pkg::TAP_IDX_W-1:0],
                      ($urandom_range(3) == 0) ? pick_value() : pcm_t'(0));
        end else if (roll < 75) begin
          n = $urandom_range(6);
          repeat (n)
            send_word($urandom_range(1) ? shfc_pkg::OP_LOAD_L : shfc_pkg::OP_LOAD_R,
                      shfc_pkg::TAP_IDX_W'($urandom_range(TAPS_TB - 1)), pick_value());
          n = $urandom_range(10, 2);
          repeat (n)
            send_word(shfc_pkg::OP_SAMPLE, shfc_pkg::TAP_IDX_W'($urandom), pick_value());
        end else begin
          send_word(shfc_pkg::OP_W'($urandom_range(3)), shfc_pkg::TAP_IDX_W'($urandom),
                    pick_value());
        end
      end
      wait_drained();
    end

    $display("covered %0d samples, %0d tap loads, %0d ignored words over %0d gain settings",
             sb.n_samples, sb.n_loads, sb.n_ignored, n_gain_writes + 1);
    $display("%0d stereo words compared, %0d mismatches, %0d never arrived",
             sb.n_results, sb.n_mismatches, sb.pending_pairs.size());
    if (sb.n_mismatches == 0 && sb.pending_pairs.size() == 0) begin
      $display("stereo_hrtf_fir_convolver: match");
    end else begin
      $display("stereo_hrtf_fir_convolver: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("stereo_hrtf_fir_convolver: mismatch");
    $finish;
  end

endmodule
